FILE: sv/button_debounce_hold_repeat_unit_macros.svh
// Assertion macros shared by the button debounce/hold/repeat RTL.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BDHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BDHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bdhr_pkg.sv
// Shared types and constants for the button debounce/hold/repeat unit.
// No dependencies.
package bdhr_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int FIELD_W     = 3;
    localparam int COUNT_W     = 8;
    localparam int DEB_W       = 6;
    localparam int HOLD_W      = 7;
    localparam int RPT_W       = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd2;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 6'd5;
    localparam logic [HOLD_W-1:0]  HOLD_RST     = 7'd100;
    localparam logic [RPT_W-1:0]   REPEAT_RST   = 7'd25;
    localparam logic [COUNT_W-1:0] WRAP_RST     = 8'd125;

    typedef struct packed {
        logic [DEB_W-1:0]   debounce_ticks;
        logic [HOLD_W-1:0]  hold_ticks;
        logic [COUNT_W-1:0] wrap_at;
    } cfg_t;

    typedef struct packed {
        logic press_ev;
        logic rel_ev;
        logic hold_ev;
    } btn_ev_t;

    typedef struct packed {
        logic [FIELD_W-1:0] press;
        logic [FIELD_W-1:0] rel;
        logic [FIELD_W-1:0] hold;
    } events_t;

endpackage

FILE: sv/bdhr_cfg_regs.sv
// Configuration registers: debounce, hold and repeat tick counts.
// Also keeps hold + repeat precomputed. Depends on bdhr_pkg.
module bdhr_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bdhr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdhr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bdhr_pkg::cfg_t                     cfg
);
    import bdhr_pkg::*;

    logic [DEB_W-1:0]   debounce_reg, debounce_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic [RPT_W-1:0]   repeat_reg, repeat_next;
    logic [COUNT_W-1:0] wrap_reg, wrap_next;

    always_comb
    begin
        debounce_next = debounce_reg;
        hold_next     = hold_reg;
        repeat_next   = repeat_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_next = cfg_data[DEB_W-1:0];
                REG_HOLD:     hold_next     = cfg_data[HOLD_W-1:0];
                REG_REPEAT:   repeat_next   = cfg_data[RPT_W-1:0];
                default:      ; // unmapped index, ignored
            endcase
        end
        wrap_next = COUNT_W'(hold_next) + COUNT_W'(repeat_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            hold_reg     <= HOLD_RST;
            repeat_reg   <= REPEAT_RST;
            wrap_reg     <= WRAP_RST;
        end
        else
        begin
            debounce_reg <= debounce_next;
            hold_reg     <= hold_next;
            repeat_reg   <= repeat_next;
            wrap_reg     <= wrap_next;
        end
    end

    assign cfg.debounce_ticks = debounce_reg;
    assign cfg.hold_ticks     = hold_reg;
    assign cfg.wrap_at        = wrap_reg;

endmodule

FILE: sv/bdhr_button.sv
// One button: press counter with press, short-release and hold/repeat events.
// Depends on bdhr_pkg and the assertion macro header.
`include "button_debounce_hold_repeat_unit_macros.svh"

module bdhr_button (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              pressed,
    input  bdhr_pkg::cfg_t    cfg,
    output bdhr_pkg::btn_ev_t ev
);
    import bdhr_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               in_debounce;

    // events are judged on the count before this tick's update
    assign in_debounce = (count_reg != '0) && (count_reg < COUNT_W'(cfg.debounce_ticks));
    assign ev.press_ev = pressed && (count_reg == '0);
    assign ev.rel_ev   = !pressed && (count_reg >= COUNT_W'(cfg.debounce_ticks))
                         && (count_reg < COUNT_W'(cfg.hold_ticks));
    assign ev.hold_ev  = pressed && (count_reg == COUNT_W'(cfg.hold_ticks));

    always_comb
    begin
        count_inc = (pressed || in_debounce) ? count_reg + 1'b1 : '0;
        if (count_inc >= cfg.wrap_at)
            count_next = COUNT_W'(cfg.hold_ticks);
        else
            count_next = count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (advance)
            count_reg <= count_next;
    end

    `BDHR_ASSERT_NEXT(a_count_holds_idle, !advance, $stable(count_reg),
                      "count moved without a tick")
    `BDHR_ASSERT_NOW(a_press_rel_excl, 1'b1, !(ev.press_ev && ev.rel_ev),
                     "press and release together")
    `BDHR_ASSERT_NEXT(a_release_clears,
                      advance && ev.rel_ev && (cfg.wrap_at != '0),
                      count_reg == '0, "release did not clear count")

endmodule

FILE: sv/bdhr_result_reg.sv
// Result register between the event logic and the output channel.
// Depends on bdhr_pkg and the assertion macro header.
`include "button_debounce_hold_repeat_unit_macros.svh"

module bdhr_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bdhr_pkg::events_t ev_in,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              busy,
    output bdhr_pkg::events_t ev_out
);
    import bdhr_pkg::*;

    logic    valid_reg;
    events_t ev_reg;

    // full and stalled: the input side must wait
    assign busy = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ev_reg <= ev_in;
    end

    assign out_valid = valid_reg;
    assign ev_out    = ev_reg;

    `BDHR_ASSERT_NEXT(a_load_valid, load, valid_reg, "loaded result not presented")
    `BDHR_ASSERT_NEXT(a_drain, valid_reg && !out_stall && !load, !valid_reg,
                      "taken result repeated")
    `BDHR_ASSERT_NOW(a_no_overwrite, busy, !load, "pending result overwritten")

endmodule

FILE: sv/button_debounce_hold_repeat_unit.sv
// Three-button debounce with press, short-release and hold/repeat events.
// One tick per input transfer, one result transfer per tick, one transfer per
// cycle sustained. Each tick updates one 8-bit press counter per button and
// registers the press, release and hold event bits into a result register; the
// path is a counter increment, a compare against hold + repeat and the event
// compares. Events are judged on the counter from before the tick. A press
// fires on the first pressed tick; a release fires when the button is let go
// with the count in [debounce, hold); a hold fires at count == hold and, as the
// counter wraps from hold + repeat back to hold, every repeat ticks after.
// Bounce during the first debounce ticks is ignored. The result register takes
// a new tick while the previous result is taken in the same cycle, so input
// stall is raised only when the result is held by output stall. Configuration
// (debounce, hold, repeat at indices 0, 1, 2) must be written only when idle;
// unchecked. Depends on bdhr_pkg, bdhr_cfg_regs, bdhr_button, bdhr_result_reg.
module button_debounce_hold_repeat_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [bdhr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdhr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel: one tick per transfer
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bdhr_pkg::FIELD_W-1:0]    pin_levels,
    // output channel: one result per tick
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bdhr_pkg::FIELD_W-1:0]    press_events,
    output logic [bdhr_pkg::FIELD_W-1:0]    release_events,
    output logic [bdhr_pkg::FIELD_W-1:0]    hold_events
);
    import bdhr_pkg::*;

    cfg_t                   cfg;
    logic                   tick;
    logic [NUM_BUTTONS-1:0] pressed;
    btn_ev_t                btn_ev [NUM_BUTTONS];
    events_t                ev_comb;
    events_t                ev_out;

    assign tick = in_valid && !in_stall;

    bdhr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pins are active low; buttons beyond the pin field read as pressed
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_btn
        if (i < FIELD_W)
        begin : g_pin
            assign pressed[i] = !pin_levels[i];
        end
        else
        begin : g_nopin
            assign pressed[i] = 1'b1;
        end

        bdhr_button u_btn (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (tick),
            .pressed (pressed[i]),
            .cfg     (cfg),
            .ev      (btn_ev[i])
        );
    end

    // gather event bits; buttons beyond the field width are dropped
    always_comb
    begin
        ev_comb = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (i < FIELD_W)
            begin
                ev_comb.press[i] = btn_ev[i].press_ev;
                ev_comb.rel[i]   = btn_ev[i].rel_ev;
                ev_comb.hold[i]  = btn_ev[i].hold_ev;
            end
        end
    end

    bdhr_result_reg u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (tick),
        .ev_in     (ev_comb),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (in_stall),
        .ev_out    (ev_out)
    );

    assign press_events   = ev_out.press;
    assign release_events = ev_out.rel;
    assign hold_events    = ev_out.hold;

endmodule
